[design/pmsm_pkg.sv]
// ----------------------------------------------------------------------------
// pmsm_pkg: shared constants and types for the phrase substring matcher
// Phrase table, window geometry, result status codes and the result word.
// ----------------------------------------------------------------------------
package pmsm_pkg;

  localparam int WINDOW_CHARS = 16;
  localparam int WIN_IDX_W    = $clog2(WINDOW_CHARS);
  localparam int PHRASE_COUNT = 17;
  localparam int PHRASE_IDX_W = 5;
  localparam int KEPT_W       = 8;
  localparam logic [KEPT_W-1:0] KEPT_MAX = '1;  // 255 kept characters at most
  localparam int CNT_W        = 32;

  localparam logic [1:0] ST_IGNORED = 2'd0;
  localparam logic [1:0] ST_MATCHED = 2'd1;
  localparam logic [1:0] ST_NO_HIT  = 2'd2;

  // Right-justified in the window: last character of a phrase sits at the
  // newest window position, unused leading bytes are zero (don't care).
  localparam logic [WINDOW_CHARS*8-1:0] PHRASE_TEXT [PHRASE_COUNT] = '{
    "open settings", "new invoice", "lock screen", "read screen",
    "volume up", "volume down", "mute", "unmute",
    "workspace one", "workspace two", "workspace three", "switch workspace",
    "take screenshot", "open terminal", "open files", "open accounts",
    "file gst return"
  };

  // Byte phrase p expects at window position pos (0 oldest); zero = unused.
  function automatic logic [7:0] phrase_byte(input int p, input logic [WIN_IDX_W-1:0] pos);
    logic [WIN_IDX_W-1:0] rpos;
    rpos = WIN_IDX_W'(WINDOW_CHARS - 1) - pos;
    return PHRASE_TEXT[p][rpos*8 +: 8];
  endfunction

  typedef struct packed {
    logic [1:0]              status;
    logic [PHRASE_IDX_W-1:0] phrase_index;
    logic [CNT_W-1:0]        utterances_seen;
    logic [CNT_W-1:0]        unrecognised_seen;
    logic [CNT_W-1:0]        dispatched_seen;
  } result_t;

endpackage

[design/pmsm_if.sv]
// ----------------------------------------------------------------------------
// pmsm_in_if / pmsm_out_if: valid/ready channels of the phrase matcher
// Input carries one character word, output carries one result word.
// ----------------------------------------------------------------------------
interface pmsm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface pmsm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  phrase_index;
  logic [31:0] utterances_seen;
  logic [31:0] unrecognised_seen;
  logic [31:0] dispatched_seen;
  modport source (output valid, output status, output phrase_index, output utterances_seen,
                  output unrecognised_seen, output dispatched_seen, input ready);
  modport sink   (input valid, input status, input phrase_index, input utterances_seen,
                  input unrecognised_seen, input dispatched_seen, output ready);
endinterface

[design/phrase_table_substring_matcher_top.sv]
// ----------------------------------------------------------------------------
// phrase_table_substring_matcher_top: streaming multi-phrase substring matcher
// A result word is written into the output queue registers when its terminator is accepted.
// Throughput: 1 character word per cycle while the output queue is not full; the window
// shifts on each kept character and match flags of the shifted window fold into the found bits in the cycle after.
// A 2-entry output queue keeps input flowing while a result waits.
// Reset (rst_n low, synchronous): window, found bits, counters, enable cleared.
// ----------------------------------------------------------------------------
module phrase_table_substring_matcher_top
  import pmsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  pmsm_in_if.sink           in_ch,
  pmsm_out_if.source        out_ch
);

  logic                    enable_r;
  logic [KEPT_W-1:0]       kept_r, kept_nxt;
  logic                    nonempty_r, nonempty_nxt;
  logic                    shifted_r, shifted_nxt;
  logic [PHRASE_COUNT-1:0] found_r, found_nxt;
  logic [CNT_W-1:0]        utt_r, utt_nxt;
  logic [CNT_W-1:0]        unrec_r, unrec_nxt;
  logic [CNT_W-1:0]        disp_r, disp_nxt;

  logic [1:0]              qcnt_r, qcnt_nxt;
  result_t                 slot0_r, slot0_nxt;
  result_t                 slot1_r, slot1_nxt;

  logic                    in_acc;
  logic                    term;
  logic [7:0]              low_char;
  logic                    keep;
  logic                    do_shift;
  logic                    do_clear;
  logic [PHRASE_COUNT-1:0] match;
  logic [PHRASE_COUNT-1:0] found_all;
  logic                    push;
  logic                    pop;
  result_t                 res;

  logic [7:0]              win [WINDOW_CHARS];
  logic [PHRASE_COUNT-1:0] cell_hit [WINDOW_CHARS];

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign term     = (in_ch.char_code == 8'h00);
  assign in_ch.ready = (qcnt_r != 2'd2);

  // fold A-Z to lower case, keep letters, digits and space
  always_comb begin
    low_char = in_ch.char_code;
    if (in_ch.char_code >= 8'h41 && in_ch.char_code <= 8'h5A) begin
      low_char = in_ch.char_code + 8'h20;
    end
    keep = (low_char >= 8'h61 && low_char <= 8'h7A) ||
           (low_char >= 8'h30 && low_char <= 8'h39) || (low_char == 8'h20);
  end

  assign do_shift = in_acc && !term && keep && (kept_r != KEPT_MAX);
  assign do_clear = in_acc && term;

  // window: newest character enters at the top cell and moves down
  for (genvar i = 0; i < WINDOW_CHARS; i++) begin : g_cell
    logic [7:0] feed;
    if (i == WINDOW_CHARS - 1) begin : g_head
      assign feed = low_char;
    end else begin : g_body
      assign feed = win[i+1];
    end
    pmsm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (do_shift),
      .clear    (do_clear),
      .pos      (WIN_IDX_W'(i)),
      .char_in  (feed),
      .char_out (win[i]),
      .hit      (cell_hit[i])
    );
  end

  always_comb begin
    match = '1;
    for (int i = 0; i < WINDOW_CHARS; i++) begin
      match = match & cell_hit[i];
    end
    found_all = found_r | (shifted_r ? match : '0);
  end

  // result of the terminator in this cycle
  always_comb begin
    utt_nxt   = utt_r;
    unrec_nxt = unrec_r;
    disp_nxt  = disp_r;
    res.status       = ST_IGNORED;
    res.phrase_index = '0;
    if (enable_r && nonempty_r) begin
      utt_nxt    = utt_r + 32'd1;
      res.status = ST_NO_HIT;
      for (int p = PHRASE_COUNT - 1; p >= 0; p--) begin
        if (found_all[p]) begin
          res.status       = ST_MATCHED;
          res.phrase_index = PHRASE_IDX_W'(p);
        end
      end
      if (res.status == ST_MATCHED) begin
        disp_nxt = disp_r + 32'd1;
      end else begin
        unrec_nxt = unrec_r + 32'd1;
      end
    end
    res.utterances_seen   = utt_nxt;
    res.unrecognised_seen = unrec_nxt;
    res.dispatched_seen   = disp_nxt;
  end

  always_comb begin
    kept_nxt     = kept_r;
    nonempty_nxt = nonempty_r;
    shifted_nxt  = do_shift;
    found_nxt    = found_all;
    if (do_clear) begin
      kept_nxt     = '0;
      nonempty_nxt = 1'b0;
      found_nxt    = '0;
    end else if (in_acc) begin
      nonempty_nxt = 1'b1;
      if (do_shift) begin
        kept_nxt = kept_r + KEPT_W'(1);
      end
    end
  end

  // two-entry result queue; slot0 drives the port
  assign push = do_clear;
  assign pop  = out_ch.valid && out_ch.ready;

  always_comb begin
    qcnt_nxt  = qcnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (push && pop) begin
      slot0_nxt = res;
    end else if (pop) begin
      slot0_nxt = slot1_r;
      qcnt_nxt  = qcnt_r - 2'd1;
    end else if (push) begin
      if (qcnt_r == 2'd0) begin
        slot0_nxt = res;
      end else begin
        slot1_nxt = res;
      end
      qcnt_nxt = qcnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      kept_r     <= '0;
      nonempty_r <= 1'b0;
      shifted_r  <= 1'b0;
      found_r    <= '0;
      utt_r      <= '0;
      unrec_r    <= '0;
      disp_r     <= '0;
      qcnt_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        enable_r <= cfg_wr_data;
      end
      kept_r     <= kept_nxt;
      nonempty_r <= nonempty_nxt;
      shifted_r  <= shifted_nxt;
      found_r    <= found_nxt;
      qcnt_r     <= qcnt_nxt;
      if (do_clear) begin
        utt_r   <= utt_nxt;
        unrec_r <= unrec_nxt;
        disp_r  <= disp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_ch.valid             = (qcnt_r != 2'd0);
  assign out_ch.status            = slot0_r.status;
  assign out_ch.phrase_index      = slot0_r.phrase_index;
  assign out_ch.utterances_seen   = slot0_r.utterances_seen;
  assign out_ch.unrecognised_seen = slot0_r.unrecognised_seen;
  assign out_ch.dispatched_seen   = slot0_r.dispatched_seen;

  a_clear_after_term: assert property (@(posedge clk) disable iff (!rst_n)
    do_clear |=> (kept_r == '0) && (found_r == '0) && !nonempty_r && !shifted_r)
    else $error("utterance state not cleared after terminator");

  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (unrec_r + disp_r) == utt_r)
    else $error("matched plus unrecognised differs from utterance count");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    do_clear && enable_r && nonempty_r |=> utt_r == $past(utt_r) + 32'd1)
    else $error("utterance counter missed a step");

  a_kept_mono: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !term |=> kept_r >= $past(kept_r))
    else $error("kept length dropped mid utterance");

endmodule

[design/pmsm_cell.sv]
// ----------------------------------------------------------------------------
// pmsm_cell: one character position of the sliding window
// Holds one byte, takes its neighbor's byte on shift and flags which
// phrases accept the held byte at this position.
// ----------------------------------------------------------------------------
module pmsm_cell
  import pmsm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    shift,
  input  logic                    clear,
  input  logic [WIN_IDX_W-1:0]    pos,
  input  logic [7:0]              char_in,
  output logic [7:0]              char_out,
  output logic [PHRASE_COUNT-1:0] hit
);

  logic [7:0] char_r;
  logic [7:0] char_nxt;

  always_comb begin
    char_nxt = char_r;
    if (clear) begin
      char_nxt = '0;
    end else if (shift) begin
      char_nxt = char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_r <= '0;
    end else begin
      char_r <= char_nxt;
    end
  end

  always_comb begin
    for (int p = 0; p < PHRASE_COUNT; p++) begin
      hit[p] = (phrase_byte(p, pos) == 8'h00) || (phrase_byte(p, pos) == char_r);
    end
  end

  assign char_out = char_r;

endmodule
